@@ rtl/pal_pkg.sv @@
// shared types and codes for the positional array list
package pal_pkg;

    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [FUNC_W-1:0] OP_ERASE     = 3'd2;
    localparam logic [FUNC_W-1:0] OP_OVERWRITE = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         live_count;
        logic signed [VALUE_W-1:0] read_value;
    } pal_result_t;

endpackage

@@ rtl/positional_array_list_core.sv @@
// top level of the positional array list: stream ports, list store and result register
//
// An ordered list of signed 32-bit values in a DEPTH-word store. Each input item is one
// request (append, insert, erase, overwrite, read) and yields one result item with the
// value read, the count afterwards and a status. Requests are taken one at a time and
// tready stays low while one is at work. An accepted insert before the end and an erase of
// any entry but the last move every entry after the position one word per cycle through
// the store's single read port and single write port. A finished result waits in an output
// register, so the next request is taken while it is still held there.
module positional_array_list_core
    import pal_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], item_value[34:3], position[45:35], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], live_count[42:32], status[44:43], zeros
);

    localparam int AW = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    pal_result_t       res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic              out_valid_reg;
    pal_result_t       out_reg;

    pal_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pal_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tdata[2:0]),
        .in_value  (s_tdata[34:3]),
        .in_pos    (s_tdata[45:35]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule

@@ rtl/pal_ram.sv @@
// generic single write port, single read port ram with registered read
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/pal_seq.sv @@
// sequencer: checks requests and moves list entries one word per cycle
module pal_seq
    import pal_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        in_func,
    input  logic [VALUE_W-1:0]       in_value,
    input  logic [POS_W-1:0]         in_pos,
    output logic                     res_valid,
    input  logic                     res_ready,
    output pal_result_t              res,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [VALUE_W-1:0]       mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [VALUE_W-1:0]       mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       raddr_reg, raddr_next;
    logic                rvalid_reg, rvalid_next;
    logic                up_reg, up_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  rd_reg, rd_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic          accept;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic [AW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;

    assign accept  = in_valid && in_ready;
    assign pos_ext = PW'(in_pos);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign cnt_m1  = AW'(count_reg - CW'(1));
    assign last_idx = up_reg ? pos_reg : cnt_m1;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.read_value = rd_reg;
    assign res.live_count = POS_W'(count_reg);
    assign res.status     = st_reg;
    assign mem_raddr = (state_reg == S_IDLE) ? AW'(in_pos) : idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        raddr_next  = raddr_reg;
        rvalid_next = 1'b0;
        up_next     = up_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        st_next     = st_reg;
        mem_we      = 1'b0;
        mem_waddr   = up_reg ? raddr_reg + AW'(1) : raddr_reg - AW'(1);
        mem_wdata   = mem_rdata;

        if (rvalid_reg)
        begin
            mem_we = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_next    = '0;
                    st_next    = ST_DONE;
                    state_next = S_DONE;
                    pos_next   = AW'(in_pos);
                    val_next   = in_value;
                    case (in_func)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(in_pos);
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                idx_next   = cnt_m1;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (pos_ext == cnt_ext - PW'(1))
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                up_next    = 1'b0;
                                idx_next   = AW'(in_pos) + AW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        OP_OVERWRITE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(in_pos);
                                mem_wdata = in_value;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RWAIT;
                            end
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                rvalid_next = 1'b1;
                raddr_next  = idx_reg;
                if (idx_reg == last_idx)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = up_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (up_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_RWAIT:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        raddr_reg <= raddr_next;
        up_reg    <= up_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        rd_reg    <= rd_next;
        st_reg    <= st_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("live count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && st_reg == ST_FULL) |-> full)
        else $error("full status with room left");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |=> $stable(count_reg))
        else $error("count moved while idle");

    a_move_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> $past(state_reg) == S_SHIFT)
        else $error("shift write without a shift read");

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for positional_array_list_core with its own list predictor
`timescale 1ns / 100ps

module testbench
    import pal_pkg::*;
;

    localparam int LIST_DEPTH = 1024;

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
        int                        gap;
        bit                        calm;
        bit                        drain;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // func[2:0], item_value[34:3], position[45:35], zeros
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // read_value[31:0], live_count[42:32], status[44:43], zeros

    request_t                  request_queue[$];
    request_t                  cur_req;
    pal_result_t               owed_results[$];
    logic signed [VALUE_W-1:0] list_store [LIST_DEPTH];
    int                        list_count = 0;
    int                        plan_count = 0;
    bit                        plan_calm = 1'b0;
    bit                        plan_drain = 1'b0;
    bit                        calm_now = 1'b0;
    bit                        s_taken = 1'b0;
    int                        tx_wait = 0;
    int                        rx_wait = 0;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    int                        cycle_limit = 0;

    positional_array_list_core #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic pal_result_t apply_request(request_t r);
        pal_result_t res;
        int          p;
        res = '0;
        p = r.position;
        case (r.func)
            OP_APPEND:
                if (list_count >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_store[list_count] = r.item_value;
                    list_count++;
                end
            OP_INSERT:
                if (p > list_count)
                    res.status = ST_RANGE;
                else if (list_count >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_count; i > p; i--)
                        list_store[i] = list_store[i-1];
                    list_store[p] = r.item_value;
                    list_count++;
                end
            OP_ERASE:
                if (p >= list_count)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = p + 1; i < list_count; i++)
                        list_store[i-1] = list_store[i];
                    list_count--;
                end
            OP_OVERWRITE:
                if (p >= list_count)
                    res.status = ST_RANGE;
                else
                    list_store[p] = r.item_value;
            OP_READ:
                if (p >= list_count)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_store[p];
            default:
                ;
        endcase
        res.live_count = list_count[POS_W-1:0];
        return res;
    endfunction

    function automatic void queue_request(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                                          int p);
        request_t r;
        r.func = f;
        r.item_value = v;
        r.position = p[POS_W-1:0];
        r.calm = plan_calm;
        r.gap = plan_calm ? 0 : $urandom_range(0, 5);
        r.drain = plan_drain;
        plan_drain = 1'b0;
        request_queue.push_back(r);
        case (f)
            OP_APPEND:
                if (plan_count < LIST_DEPTH)
                    plan_count++;
            OP_INSERT:
                if (p <= plan_count && plan_count < LIST_DEPTH)
                    plan_count++;
            OP_ERASE:
                if (p < plan_count)
                    plan_count--;
            default:
                ;
        endcase
    endfunction

    function automatic void queue_random();
        int                pick;
        int                p;
        logic [FUNC_W-1:0] f;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            f = OP_APPEND;
        else if (pick < 45)
            f = OP_INSERT;
        else if (pick < 65)
            f = OP_ERASE;
        else if (pick < 75)
            f = OP_OVERWRITE;
        else if (pick < 95)
            f = OP_READ;
        else
            f = FUNC_W'($urandom_range(int'(OP_READ) + 1, 2**FUNC_W - 1));
        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 2**POS_W - 1);
        else if (f == OP_INSERT)
            p = $urandom_range(0, plan_count);
        else if (plan_count == 0)
            p = 0;
        else
            p = $urandom_range(0, plan_count - 1);
        queue_request(f, $urandom, p);
    endfunction

    function automatic void flag_error(string what, pal_result_t want, pal_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%s: expected value %0d count %0d status %0d,",
                      " got value %0d count %0d status %0d"},
                     what, want.read_value, want.live_count, want.status,
                     got.read_value, got.live_count, got.status);
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_taken)
            begin
                if (s_taken)
                    tx_wait = (request_queue.size() > 0) ? request_queue[0].gap : 0;
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0 &&
                         !(request_queue[0].drain && owed_results.size() > 0))
                begin
                    cur_req = request_queue.pop_front();
                    calm_now = cur_req.calm;
                    s_tdata <= {2'b00, cur_req.position, cur_req.item_value, cur_req.func};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
                s_taken = 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pal_result_t got;
        pal_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(pal_result_t)-1:0];
                if (owed_results.size() == 0)
                    flag_error("unexpected item", '0, got);
                else
                begin
                    want = owed_results.pop_front();
                    if (got.read_value !== want.read_value ||
                        got.live_count !== want.live_count ||
                        got.status !== want.status)
                        flag_error("mismatch", want, got);
                end
                rx_wait = calm_now ? 0 : $urandom_range(0, 5);
            end
            if (s_tvalid && s_tready)
            begin
                owed_results.push_back(apply_request(cur_req));
                s_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_limit > 0 && cycle_count > cycle_limit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // empty list and small list corners
        queue_request(OP_READ, 32'h0, 0);
        queue_request(OP_ERASE, 32'h0, 0);
        queue_request(OP_OVERWRITE, 32'h1, 0);
        queue_request(OP_INSERT, 32'h2, 1);
        queue_request(OP_INSERT, 32'h8000_0000, 0);
        queue_request(OP_APPEND, 32'h7fff_ffff, 0);
        queue_request(OP_APPEND, 32'hffff_ffff, 2**POS_W - 1);
        queue_request(OP_APPEND, 32'h0, 0);
        queue_request(OP_INSERT, 32'h5555_5555, 4);
        queue_request(OP_INSERT, 32'haaaa_aaaa, 2);
        queue_request(OP_READ, 32'h0, 0);
        queue_request(OP_READ, 32'h0, 2);
        queue_request(OP_READ, 32'h0, 5);
        queue_request(OP_OVERWRITE, 32'h1234_5678, 5);
        queue_request(OP_READ, 32'hffff_ffff, 5);
        queue_request(OP_ERASE, 32'h0, 0);
        queue_request(OP_ERASE, 32'h0, 4);
        queue_request(OP_ERASE, 32'h0, 1);
        queue_request(OP_READ, 32'h0, 2**POS_W - 1);
        queue_request(OP_INSERT, 32'h0, 2**POS_W - 1);
        queue_request(OP_ERASE, 32'h0, LIST_DEPTH);
        for (int f = int'(OP_READ) + 1; f < 2**FUNC_W; f++)
            queue_request(FUNC_W'(f), 32'hdead_beef, 0);
        queue_request(OP_READ, 32'h0, 1);

        for (int n = 0; n < 450; n++)
        begin
            if (n % 60 == 0)
                plan_calm = ($urandom_range(0, 2) == 0);
            if (n % 150 == 75)
                plan_drain = 1'b1;
            queue_random();
        end

        // fill to capacity, then the full list corners
        plan_calm = 1'b0;
        plan_drain = 1'b1;
        while (plan_count < LIST_DEPTH)
            queue_request(OP_APPEND, $urandom, 0);
        plan_drain = 1'b1;
        queue_request(OP_APPEND, 32'h1, 0);
        queue_request(OP_INSERT, 32'h2, 0);
        queue_request(OP_INSERT, 32'h3, LIST_DEPTH);
        queue_request(OP_INSERT, 32'h4, LIST_DEPTH + 1);
        queue_request(OP_READ, 32'h0, LIST_DEPTH - 1);
        queue_request(OP_READ, 32'h0, LIST_DEPTH);
        queue_request(OP_OVERWRITE, 32'h8000_0000, LIST_DEPTH - 1);
        queue_request(OP_READ, 32'h0, LIST_DEPTH - 1);
        queue_request(OP_OVERWRITE, 32'h7fff_ffff, 0);
        queue_request(OP_READ, 32'h0, 0);
        queue_request(OP_ERASE, 32'h0, LIST_DEPTH - 1);
        queue_request(OP_INSERT, 32'h0bad_cafe, 0);
        queue_request(OP_READ, 32'h0, 0);
        queue_request(OP_READ, 32'h0, LIST_DEPTH - 1);
        queue_request(OP_ERASE, 32'h0, 0);
        queue_request(OP_READ, 32'h0, 0);
        queue_request(OP_APPEND, 32'hffff_ffff, 0);
        for (int n = 0; n < 20; n++)
            queue_random();

        cycle_limit = request_queue.size() * (LIST_DEPTH + 20) * 3 + 10000;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() > 0 || s_tvalid || owed_results.size() > 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
